FILE: hw/rtl/tld_pkg.sv
// Package for the trie line duplicate detector.
// Holds the controller state type and the fixed field widths and status codes.
// No dependencies.
`timescale 1ns / 1ps

package tld_pkg;

  // Fixed widths of the item fields
  localparam int BYTE_W  = 8;
  localparam int OCC_W   = 16;

  // Status codes reported with each result item
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_FIN   = 5'b01000,
    ST_CNT   = 5'b10000
  } tld_state_t;

endpackage

FILE: hw/rtl/tld_ram.sv
// Simple dual-port synchronous RAM with registered read.
// Used for the child link table and the per-node line counts. No dependencies.
`timescale 1ns / 1ps

module tld_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/trie_line_duplicate_detector.sv
// Top level of the trie line duplicate detector: controller, output register.
// Depends on tld_pkg and tld_ram (child link table and line count table).
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one byte of a line per item,
//   in_end_of_line marks the last byte. Each byte walks or extends a trie
//   stored in a NODES x ALPHABET child link RAM; the node reached at line end
//   has its count incremented in a NODES deep count RAM.
//   Output channel (out_valid/out_ready) carries one item per line end:
//   is_duplicate (seen exactly once before), occurrence_count (saturating)
//   and status (full when the node table ran out during the line).
// Sequence: a byte that does not end a line is accepted in IDLE with the
//   link RAM read, then gets the link update in LOOK. A line-end byte then
//   reads its count in FIN and writes it in CNT, where its result is loaded
//   into the output register. Once a line has overflowed, later bytes skip
//   the lookup, and its line end goes from IDLE to FIN, which loads the result.
// Stall: a held result sits in the output register while the next bytes are
//   accepted; a new line end waits in the controller until the register
//   drains.
// Reset: rst_n low starts a clearing pass over all NODES*ALPHABET link entries
//   that zeroes both tables; in_ready stays low until it finishes.
module trie_line_duplicate_detector #(
  parameter int NODES      = 1024,
  parameter int ALPHABET   = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tld_pkg::BYTE_W-1:0]    in_line_byte,
  input  logic                          in_end_of_line,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_duplicate,
  output logic [tld_pkg::OCC_W-1:0]     out_occurrence_count,
  output logic                          out_status
);

  localparam int TOTAL = NODES * ALPHABET;
  localparam int NW    = $clog2(NODES);
  localparam int SW    = $clog2(ALPHABET);
  localparam int AW    = $clog2(TOTAL);
  localparam int CW    = COUNT_BITS;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  // Registers
  tld_pkg::tld_state_t state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [NW-1:0]       cur_r, cur_nxt;
  logic [NW:0]         free_r, free_nxt;
  logic                ovf_r, ovf_nxt;
  logic                last_r, last_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_dup_r, out_dup_nxt;
  logic [tld_pkg::OCC_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                out_status_r, out_status_nxt;

  // Memory ports
  logic          link_we, link_re;
  logic [AW-1:0] link_waddr, link_raddr;
  logic [NW-1:0] link_wdata, link_rdata;
  logic          cnt_we, cnt_re;
  logic [NW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata;

  // Datapath helpers
  logic [SW-1:0] sym;
  logic [AW-1:0] slot_addr;
  logic [CW-1:0] cnt_now;
  logic [31:0]   cnt_now_ext;
  logic          out_free;

  tld_ram #(.DEPTH(TOTAL), .WIDTH(NW)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  tld_ram #(.DEPTH(NODES), .WIDTH(CW)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Clamp the byte into the alphabet and form the link slot address
  always_comb begin
    if ({1'b0, in_line_byte} >= 9'(ALPHABET)) begin
      sym = SW'(ALPHABET - 1);
    end else begin
      sym = in_line_byte[SW-1:0];
    end
    slot_addr = AW'(cur_r) * AW'(ALPHABET) + AW'(sym);
  end

  // Saturating count update and clip to the output width
  assign cnt_now     = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + CW'(1);
  assign cnt_now_ext = 32'(cnt_now);
  assign out_free    = !out_valid_r || out_ready;

  // Controller
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    free_nxt       = free_r;
    ovf_nxt        = ovf_r;
    last_nxt       = last_r;
    slot_nxt       = slot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_dup_nxt    = out_dup_r;
    out_cnt_nxt    = out_cnt_r;
    out_status_nxt = out_status_r;
    in_ready       = 1'b0;
    link_we        = 1'b0;
    link_waddr     = slot_r;
    link_wdata     = free_r[NW-1:0];
    link_re        = 1'b0;
    link_raddr     = slot_addr;
    cnt_we         = 1'b0;
    cnt_waddr      = cur_r;
    cnt_wdata      = cnt_now;
    cnt_re         = 1'b0;
    cnt_raddr      = cur_r;

    case (state_r)
      tld_pkg::ST_CLEAR: begin
        // Zero one link entry per cycle, and the count entries on the way
        link_we    = 1'b1;
        link_waddr = clr_r;
        link_wdata = '0;
        cnt_we     = (clr_r < AW'(NODES));
        cnt_waddr  = clr_r[NW-1:0];
        cnt_wdata  = '0;
        if (clr_r == AW'(TOTAL - 1)) begin
          state_nxt = tld_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      tld_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_nxt = in_end_of_line;
          if (!ovf_r) begin
            link_re   = 1'b1;
            slot_nxt  = slot_addr;
            state_nxt = tld_pkg::ST_LOOK;
          end else if (in_end_of_line) begin
            state_nxt = tld_pkg::ST_FIN;
          end
        end
      end

      tld_pkg::ST_LOOK: begin
        // Follow the edge, or hand out a fresh node for it
        if (link_rdata == '0) begin
          if (free_r < (NW+1)'(NODES)) begin
            link_we  = 1'b1;
            cur_nxt  = free_r[NW-1:0];
            free_nxt = free_r + (NW+1)'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end else begin
          cur_nxt = link_rdata;
        end
        state_nxt = last_r ? tld_pkg::ST_FIN : tld_pkg::ST_IDLE;
      end

      tld_pkg::ST_FIN: begin
        if (ovf_r) begin
          // Table ran full during this line: report and count nothing
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_dup_nxt    = 1'b0;
            out_cnt_nxt    = '0;
            out_status_nxt = tld_pkg::STATUS_FULL;
            ovf_nxt        = 1'b0;
            cur_nxt        = '0;
            state_nxt      = tld_pkg::ST_IDLE;
          end
        end else begin
          cnt_re    = 1'b1;
          state_nxt = tld_pkg::ST_CNT;
        end
      end

      tld_pkg::ST_CNT: begin
        // Count read data holds while the output register is busy
        if (out_free) begin
          cnt_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_dup_nxt    = (cnt_rdata == CW'(1));
          out_cnt_nxt    = (cnt_now_ext > 32'hFFFF) ? 16'hFFFF : cnt_now_ext[15:0];
          out_status_nxt = tld_pkg::STATUS_OK;
          cur_nxt        = '0;
          state_nxt      = tld_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tld_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tld_pkg::ST_CLEAR;
      clr_r       <= '0;
      cur_r       <= '0;
      free_r      <= (NW+1)'(1);
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      free_r      <= free_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    out_dup_r    <= out_dup_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_is_duplicate     = out_dup_r;
  assign out_occurrence_count = out_cnt_r;
  assign out_status           = out_status_r;

`ifndef SYNTHESIS
  // Free counter never passes the table size
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= (NW+1)'(NODES))
    else $error("free node counter beyond table size");

  // An edge is only created where none existed
  a_link_new: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tld_pkg::ST_LOOK && link_we) |-> (link_rdata == '0))
    else $error("existing child link overwritten");

  // A full-status result carries no count
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == tld_pkg::STATUS_FULL) |->
      (out_occurrence_count == '0 && !out_is_duplicate))
    else $error("full status with nonzero count");

  // One item at a time: ready drops after each item that needs a lookup or ends a line
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (!ovf_r || in_end_of_line)) |=> !in_ready)
    else $error("item accepted while previous one in flight");
`endif

endmodule
